// ===== src/qmm_pkg.sv =====
// Quadrotor motor mixer package: shared types, widths and register codes.
// No dependencies.
package qmm_pkg;

    localparam int SPEED_BITS_DEF = 16;
    localparam int BW             = 47;   // scaled vector element, signed
    localparam int PW             = 63;   // element times coefficient
    localparam int AW             = 64;   // accumulator
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MIX_ROW_0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_ROW_1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_ROW_2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_ROW_3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOVER_FORCE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THRUST_RECIP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MOMENT_RECIP = 3'd6;

    typedef struct packed {
        logic signed [31:0] thrust_command;
        logic signed [31:0] roll_moment;
        logic signed [31:0] pitch_moment;
        logic signed [31:0] yaw_moment;
    } qmm_cmd_t;

    typedef struct packed {
        logic [15:0] motor_speed_0;
        logic [15:0] motor_speed_1;
        logic [15:0] motor_speed_2;
        logic [15:0] motor_speed_3;
        logic [3:0]  clamp_mask;
    } qmm_result_t;

    typedef struct packed {
        logic [3:0][63:0] mix_row;
        logic [30:0]      hover_force;
        logic [31:0]      thrust_recip;
        logic [31:0]      moment_recip;
    } qmm_cfg_t;

endpackage

// ===== src/qmm_cfg.sv =====
// Configuration register file for the motor mixer.
// Depends on qmm_pkg.
module qmm_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [qmm_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [qmm_pkg::CFG_DATA_W-1:0]   wr_data,
    output qmm_pkg::qmm_cfg_t                cfg
);
    import qmm_pkg::*;

    qmm_cfg_t cfg_reg;
    qmm_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_MIX_ROW_0:    cfg_next.mix_row[0]   = wr_data;
                REG_MIX_ROW_1:    cfg_next.mix_row[1]   = wr_data;
                REG_MIX_ROW_2:    cfg_next.mix_row[2]   = wr_data;
                REG_MIX_ROW_3:    cfg_next.mix_row[3]   = wr_data;
                REG_HOVER_FORCE:  cfg_next.hover_force  = wr_data[30:0];
                REG_THRUST_RECIP: cfg_next.thrust_recip = wr_data[31:0];
                REG_MOMENT_RECIP: cfg_next.moment_recip = wr_data[31:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/qmm_scale.sv =====
// Force/moment scaling: hover add, 32x32 scale by reciprocals, saturation.
// Three register stages. Depends on qmm_pkg.
module qmm_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  qmm_pkg::qmm_cmd_t             cmd,
    input  qmm_pkg::qmm_cfg_t             cfg,
    output logic                          valid_out,
    output logic signed [qmm_pkg::BW-1:0] b [4]
);
    import qmm_pkg::*;

    localparam logic [BW-1:0] B_POS_MAX = {2'b00, {(BW-2){1'b1}}};
    localparam logic [BW-1:0] B_NEG_MIN = {2'b11, {(BW-2){1'b0}}};

    logic signed [32:0] x [4];
    logic [32:0]        mag_next [4];
    logic [32:0]        mag_reg  [4];
    logic [3:0]         neg_next;
    logic [3:0]         neg_reg;
    logic [3:0]         neg2_reg;
    logic [3:0]         hi_reg;
    logic [63:0]        prod_next [4];
    logic [63:0]        prod_reg  [4];
    logic [31:0]        fac [4];
    logic [63:0]        p [4];
    logic [BW-1:0]      b_next [4];
    logic [BW-1:0]      b_reg  [4];
    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;

    always_comb
    begin
        x[0] = 33'($signed(cmd.thrust_command)) + $signed({2'b00, cfg.hover_force});
        x[1] = 33'($signed(cmd.roll_moment));
        x[2] = 33'($signed(cmd.pitch_moment));
        x[3] = 33'($signed(cmd.yaw_moment));
        fac[0] = cfg.thrust_recip;
        fac[1] = cfg.thrust_recip;
        fac[2] = cfg.thrust_recip;
        fac[3] = cfg.moment_recip;
        for (int j = 0; j < 4; j++)
        begin
            neg_next[j]  = x[j][32];
            mag_next[j]  = x[j][32] ? 33'(-x[j]) : 33'(x[j]);
            prod_next[j] = 64'(mag_reg[j][31:0]) * 64'(fac[j]);
            // magnitude 2^32 has a zero low word
            p[j] = hi_reg[j] ? {fac[j], 32'd0} : prod_reg[j];
            if (neg2_reg[j])
                b_next[j] = (p[j][63:BW-2] != '0) ? B_NEG_MIN
                                                  : BW'(-{2'b00, p[j][BW-3:0]});
            else
                b_next[j] = (p[j][63:BW-2] != '0) ? B_POS_MAX
                                                  : {2'b00, p[j][BW-3:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        neg2_reg <= neg_reg;
        for (int j = 0; j < 4; j++)
        begin
            mag_reg[j]  <= mag_next[j];
            hi_reg[j]   <= mag_reg[j][32];
            prod_reg[j] <= prod_next[j];
            b_reg[j]    <= b_next[j];
        end
    end

    assign valid_out = v3_reg;
    assign b[0] = $signed(b_reg[0]);
    assign b[1] = $signed(b_reg[1]);
    assign b[2] = $signed(b_reg[2]);
    assign b[3] = $signed(b_reg[3]);

endmodule

// ===== src/qmm_mix.sv =====
// Inverse mixing matrix multiply, accumulate tree, clamp and saturate.
// Four register stages. Depends on qmm_pkg.
module qmm_mix #(
    parameter int SPEED_BITS = qmm_pkg::SPEED_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  logic signed [qmm_pkg::BW-1:0] b [4],
    input  qmm_pkg::qmm_cfg_t             cfg,
    output logic                          valid_out,
    output logic [2*SPEED_BITS-1:0]       w [4],
    output logic [3:0]                    mask
);
    import qmm_pkg::*;

    localparam int WB  = 2 * SPEED_BITS;
    localparam int SHW = AW - 28;
    localparam int XW  = (WB > SHW) ? WB : SHW;
    localparam logic [XW-1:0] LIMIT = XW'({WB{1'b1}});

    logic signed [PW-1:0] prod_next [4][4];
    logic signed [PW-1:0] prod_reg  [4][4];
    logic signed [AW-1:0] pair_next [4][2];
    logic signed [AW-1:0] pair_reg  [4][2];
    logic signed [AW-1:0] acc_next  [4];
    logic signed [AW-1:0] acc_reg   [4];
    logic [XW-1:0]        shx [4];
    logic [WB-1:0]        w_next [4];
    logic [WB-1:0]        w_reg  [4];
    logic [3:0]           mask_next;
    logic [3:0]           mask_reg;
    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic                 v4_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < 4; j++)
                prod_next[k][j] = PW'(b[j]) * PW'($signed(cfg.mix_row[k][16*j +: 16]));
            pair_next[k][0] = AW'(prod_reg[k][0]) + AW'(prod_reg[k][1]);
            pair_next[k][1] = AW'(prod_reg[k][2]) + AW'(prod_reg[k][3]);
            acc_next[k]     = pair_reg[k][0] + pair_reg[k][1];
            shx[k]          = XW'(acc_reg[k][AW-1:28]);
            if (acc_reg[k][AW-1])
            begin
                w_next[k]    = '0;
                mask_next[k] = 1'b1;
            end
            else
            begin
                w_next[k]    = (shx[k] > LIMIT) ? WB'(LIMIT) : WB'(shx[k]);
                mask_next[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        pair_reg <= pair_next;
        acc_reg  <= acc_next;
        w_reg    <= w_next;
        mask_reg <= mask_next;
    end

    assign valid_out = v4_reg;
    assign w         = w_reg;
    assign mask      = mask_reg;

endmodule

// ===== src/qmm_isqrt.sv =====
// Four-lane pipelined integer square root, one root bit per stage.
// Carries the clamp mask alongside. Depends on qmm_pkg.
module qmm_isqrt #(
    parameter int SPEED_BITS = qmm_pkg::SPEED_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    input  logic [2*SPEED_BITS-1:0] w [4],
    input  logic [3:0]              mask_in,
    output logic                    valid_out,
    output qmm_pkg::qmm_result_t    result
);
    import qmm_pkg::*;

    localparam int SB = SPEED_BITS;
    localparam int WB = 2 * SB;
    localparam int RW = SB + 2;

    logic [RW-1:0] rem_w  [SB+1][4];
    logic [SB-1:0] root_w [SB+1][4];
    logic [WB-1:0] rest_w [SB+1][4];
    logic          vld_w  [SB+1];
    logic [3:0]    msk_w  [SB+1];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            rem_w[0][l]  = '0;
            root_w[0][l] = '0;
            rest_w[0][l] = w[l];
        end
        vld_w[0] = valid_in;
        msk_w[0] = mask_in;
    end

    for (genvar s = 0; s < SB; s++)
    begin : g_stage
        logic [RW-1:0] rem_next  [4];
        logic [RW-1:0] rem_reg   [4];
        logic [SB-1:0] root_next [4];
        logic [SB-1:0] root_reg  [4];
        logic [WB-1:0] rest_reg  [4];
        logic [RW-1:0] rs        [4];
        logic [RW-1:0] trial     [4];
        logic          vld_reg;
        logic [3:0]    msk_reg;

        always_comb
        begin
            for (int l = 0; l < 4; l++)
            begin
                rs[l]    = {rem_w[s][l][RW-3:0], rest_w[s][l][WB-1 -: 2]};
                trial[l] = {root_w[s][l], 2'b01};
                if (rs[l] >= trial[l])
                begin
                    rem_next[l]  = rs[l] - trial[l];
                    root_next[l] = {root_w[s][l][SB-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l]  = rs[l];
                    root_next[l] = {root_w[s][l][SB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else
                vld_reg <= vld_w[s];
        end

        always_ff @(posedge clk)
        begin
            msk_reg <= msk_w[s];
            for (int l = 0; l < 4; l++)
            begin
                rem_reg[l]  <= rem_next[l];
                root_reg[l] <= root_next[l];
                rest_reg[l] <= {rest_w[s][l][WB-3:0], 2'b00};
            end
        end

        always_comb
        begin
            for (int l = 0; l < 4; l++)
            begin
                rem_w[s+1][l]  = rem_reg[l];
                root_w[s+1][l] = root_reg[l];
                rest_w[s+1][l] = rest_reg[l];
            end
            vld_w[s+1] = vld_reg;
            msk_w[s+1] = msk_reg;
        end
    end

    assign valid_out            = vld_w[SB];
    assign result.motor_speed_0 = 16'(root_w[SB][0]);
    assign result.motor_speed_1 = 16'(root_w[SB][1]);
    assign result.motor_speed_2 = 16'(root_w[SB][2]);
    assign result.motor_speed_3 = 16'(root_w[SB][3]);
    assign result.clamp_mask    = msk_w[SB];

endmodule

// ===== src/quadrotor_motor_mixer_unit.sv =====
// Top level of the quadrotor motor mixer.
// Depends on qmm_pkg, qmm_cfg, qmm_scale, qmm_mix, qmm_isqrt.

// A command is taken on every cycle that start is high; busy is always low.
// Each command yields one result, marked by result_valid for one cycle, after
// three scaling stages, four mixing stages and one square root stage per
// speed bit. The receiver cannot stall; results come out in command order at
// one per cycle. Configuration writes are always accepted and take effect at
// once, so change them only while no command is in flight.
module quadrotor_motor_mixer_unit #(
    parameter int SPEED_BITS = qmm_pkg::SPEED_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  qmm_pkg::qmm_cmd_t              cmd,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [qmm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qmm_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           result_valid,
    output qmm_pkg::qmm_result_t           result
);
    import qmm_pkg::*;

    qmm_cfg_t                cfg;
    logic                    sc_valid;
    logic signed [BW-1:0]    b [4];
    logic                    mx_valid;
    logic [2*SPEED_BITS-1:0] w [4];
    logic [3:0]              mask;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    qmm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    qmm_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start & ~busy),
        .cmd       (cmd),
        .cfg       (cfg),
        .valid_out (sc_valid),
        .b         (b)
    );

    qmm_mix #(
        .SPEED_BITS (SPEED_BITS)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (sc_valid),
        .b         (b),
        .cfg       (cfg),
        .valid_out (mx_valid),
        .w         (w),
        .mask      (mask)
    );

    qmm_isqrt #(
        .SPEED_BITS (SPEED_BITS)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (mx_valid),
        .w         (w),
        .mask_in   (mask),
        .valid_out (result_valid),
        .result    (result)
    );

endmodule

// ===== tb/tb_quadrotor_motor_mixer_unit.sv =====
// Testbench for quadrotor_motor_mixer_unit: directed and random commands checked
// against an in-bench fixed-point mixer predictor through a scoreboard class.
// Depends on qmm_pkg and the quadrotor_motor_mixer_unit RTL.
`timescale 1ns / 100ps

module tb_quadrotor_motor_mixer_unit;
    import qmm_pkg::*;

    localparam int LATENCY  = 7 + SPEED_BITS_DEF;
    localparam int WATCHDOG = 20000;

    class mixer_scoreboard;
        qmm_result_t pending_speeds[$];
        logic [3:0][63:0] rows;
        logic [30:0] hover;
        logic [31:0] t_recip;
        logic [31:0] m_recip;
        int errors;
        int checked;

        function new();
            rows = '0; hover = '0; t_recip = '0; m_recip = '0;
            errors = 0; checked = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                REG_MIX_ROW_0, REG_MIX_ROW_1, REG_MIX_ROW_2, REG_MIX_ROW_3:
                    rows[idx[1:0]] = val;
                REG_HOVER_FORCE:  hover = val[30:0];
                REG_THRUST_RECIP: t_recip = val[31:0];
                REG_MOMENT_RECIP: m_recip = val[31:0];
                default: ;
            endcase
        endfunction

        function logic signed [63:0] scaled(logic signed [63:0] x, logic [31:0] f);
            logic [63:0] mag;
            logic [63:0] p;
            mag = (x < 0) ? -x : x;
            p = mag * {32'd0, f};
            if (x < 0)
                return (p >= 64'd35184372088832) ? -64'sd35184372088832 : -$signed(p);
            return (p > 64'd35184372088831) ? 64'sd35184372088831 : $signed(p);
        endfunction

        function logic [63:0] root_floor(logic [63:0] n);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_command(qmm_cmd_t c);
            logic signed [63:0] vec[4];
            logic signed [127:0] acc;
            logic signed [15:0] cf;
            logic [63:0] w;
            logic [63:0] sp;
            qmm_result_t r;
            vec[0] = scaled(64'(c.thrust_command) + $signed({33'd0, hover}), t_recip);
            vec[1] = scaled(64'(c.roll_moment), t_recip);
            vec[2] = scaled(64'(c.pitch_moment), t_recip);
            vec[3] = scaled(64'(c.yaw_moment), m_recip);
            r = '0;
            for (int k = 0; k < 4; k++)
            begin
                acc = 0;
                for (int j = 0; j < 4; j++)
                begin
                    cf = rows[k][16*j +: 16];
                    acc = acc + 128'(vec[j]) * 128'(cf);
                end
                if (acc < 0)
                begin
                    w = 0;
                    r.clamp_mask[k] = 1'b1;
                end
                else
                begin
                    w = acc[91:28];
                    if (acc[127:28] > 100'hFFFFFFFF) w = 64'hFFFFFFFF;
                end
                sp = root_floor(w);
                case (k)
                    0: r.motor_speed_0 = sp[15:0];
                    1: r.motor_speed_1 = sp[15:0];
                    2: r.motor_speed_2 = sp[15:0];
                    default: r.motor_speed_3 = sp[15:0];
                endcase
            end
            pending_speeds.push_back(r);
        endfunction

        function void check_result(qmm_result_t got);
            qmm_result_t exp_r;
            checked++;
            if (pending_speeds.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none, actual %h", $time, got);
                return;
            end
            exp_r = pending_speeds.pop_front();
            if (got.motor_speed_0 !== exp_r.motor_speed_0 ||
                got.motor_speed_1 !== exp_r.motor_speed_1 ||
                got.motor_speed_2 !== exp_r.motor_speed_2 ||
                got.motor_speed_3 !== exp_r.motor_speed_3 ||
                got.clamp_mask !== exp_r.clamp_mask)
            begin
                errors++;
                $display("%0t mismatch: expected %h, actual %h", $time, exp_r, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    qmm_cmd_t cmd;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic result_valid;
    qmm_result_t result;

    mixer_scoreboard sb;
    int idle_cycles;
    int sent;

    quadrotor_motor_mixer_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
    );

    always
    begin
        clk = 1'b0; #2;
        clk = 1'b1; #2;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid) sb.check_result(result);
        if (rst_n && ((start && !busy) || result_valid || (cfg_valid && cfg_ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("quadrotor_motor_mixer_unit regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3, 4: return $urandom_range(0, 32'h000F_FFFF);
            5: return -$urandom_range(0, 32'h000F_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    // valid stays high across consecutive writes; send_cmd drops it
    task automatic write_cfg(logic [2:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic drain();
        cmd <= cmd;
        start <= 1'b0;
        while (sb.pending_speeds.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic send_cmd(qmm_cmd_t c, bit pause);
        int g;
        g = pause ? gap_len() : 0;
        cfg_valid <= 1'b0;
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_command(c);
        sent++;
    endtask

    function automatic qmm_cmd_t rand_cmd();
        qmm_cmd_t c;
        c.thrust_command = rand_field();
        c.roll_moment = rand_field();
        c.pitch_moment = rand_field();
        c.yaw_moment = rand_field();
        return c;
    endfunction

    function automatic logic [63:0] rand_row(int kind);
        logic [63:0] v;
        if (kind == 0) return 64'd0;
        if (kind == 1) return 64'h8000_8000_8000_8000;
        if (kind == 2) return 64'h7FFF_7FFF_7FFF_7FFF;
        v = {$urandom, $urandom};
        return v;
    endfunction

    task automatic load_setting(int kind);
        for (int k = 0; k < 4; k++)
            write_cfg(k[2:0], rand_row(kind == 3 ? $urandom_range(0, 3) : kind));
        case (kind)
            0: write_cfg(REG_HOVER_FORCE, 64'd0);
            1: write_cfg(REG_HOVER_FORCE, 64'hFFFF_FFFF_FFFF_FFFF);
            default: write_cfg(REG_HOVER_FORCE, {$urandom, $urandom});
        endcase
        case (kind)
            0: write_cfg(REG_THRUST_RECIP, 64'd0);
            1: write_cfg(REG_THRUST_RECIP, 64'hFFFF_FFFF_0000_FFFF);
            2: write_cfg(REG_THRUST_RECIP, 64'hFFFF_FFFF);
            default: write_cfg(REG_THRUST_RECIP, $urandom_range(0, 70000));
        endcase
        case (kind)
            0: write_cfg(REG_MOMENT_RECIP, 64'd0);
            1, 2: write_cfg(REG_MOMENT_RECIP, 64'hFFFF_FFFF);
            default: write_cfg(REG_MOMENT_RECIP, {$urandom, $urandom});
        endcase
        write_cfg(3'd7, {$urandom, $urandom});
    endtask

    initial
    begin
        qmm_cmd_t c;
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_cycles = 0;
        sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero matrix and reciprocals at reset
        send_cmd(rand_cmd(), 1'b0);
        drain();
        load_setting(2);
        c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_cmd(c, 1'b0);
        c = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_cmd(c, 1'b0);
        c = '0;
        send_cmd(c, 1'b0);
        c = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        send_cmd(c, 1'b1);
        drain();
        load_setting(3);
        write_cfg(REG_MIX_ROW_0, 64'h0000_0000_0000_1000);
        write_cfg(REG_HOVER_FORCE, 64'h0000_8000);
        write_cfg(REG_THRUST_RECIP, 64'd1);
        for (int i = 0; i < 6; i++)
        begin
            c = '{32'(i * 32'h1_8000), 32'(i), -32'(i), 32'h0};
            send_cmd(c, 1'b0);
        end
        for (int i = 0; i < 10; i++) send_cmd(rand_cmd(), 1'b1);
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            load_setting(ph % 4);
            for (int i = 0; i < 160; i++)
                send_cmd(rand_cmd(), ($urandom_range(0, 3) == 0) && (ph % 3 != 0));
            drain();
        end

        drain();
        $display("covered %0d commands over 14 register settings incl. zero and extreme",
                 sent);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending_speeds.size() == 0)
            $display("quadrotor_motor_mixer_unit regression: pass");
        else
            $display("quadrotor_motor_mixer_unit regression: fail");
        $finish;
    end
endmodule
